/* hdl/irt_pkg.sv */
// Shared types and constants for the integer-to-radix-text converter.
// No dependencies; the other files of the block import this package, apart from irt_ram.
package irt_pkg;

  localparam int unsigned BASE_W  = 6;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 6;

  localparam logic [BASE_W-1:0]  BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0]  BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0]  BASE_DEC   = 6'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 6'd35;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_NONE  = 8'h00;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture value and base of a new request
    logic step;       // one restoring-division bit step
    logic store;      // write the remainder digit and clear the remainder
    logic rd_en;      // read one digit from the digit store
    logic out_minus;  // load a '-' into the output register
    logic out_digit;  // load the digit just read into the output register
    logic out_inv;    // load the invalid-base marker into the output register
    logic out_last;   // last flag that goes with the character loaded
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic invalid;    // captured base lies outside 2 to 36
    logic neg_dec;    // captured value was negative and the base is ten
    logic quot_zero;  // running quotient has reached zero
    logic out_free;   // output register can take a character this cycle
  } status_t;

  // Maps a digit value to its lower-case ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] dc;
    dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
    if (dc < DIGIT_TEN) begin
      return CHAR_ZERO + {2'b00, dc};
    end else begin
      return CHAR_LOW_A + {2'b00, dc - DIGIT_TEN};
    end
  endfunction

endpackage

/* hdl/irt_stream_if.sv */
// Valid/ready channel interfaces for the request and character streams.
// Depends on irt_pkg for the fixed field widths.
interface irt_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  import irt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic [BASE_W-1:0]      base;

  modport source (output valid, output value, output base, input ready);
  modport sink   (input valid, input value, input base, output ready);
endinterface

interface irt_out_if;
  import irt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;
  logic              invalid_base;

  modport source (output valid, output char_code, output last, output invalid_base,
                  input ready);
  modport sink   (input valid, input char_code, input last, input invalid_base,
                  output ready);
endinterface

/* hdl/irt_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module irt_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/irt_datapath.sv */
// Datapath: bit-serial divider by the base, digit store and output register.
// Depends on irt_pkg and irt_ram.
module irt_datapath
  import irt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cmd_t                             cmd_i,
  output status_t                          status_o,
  input  logic [$clog2(VALUE_WIDTH)-1:0]   wr_addr_i,
  input  logic [$clog2(VALUE_WIDTH)-1:0]   rd_addr_i,
  input  logic [VALUE_WIDTH-1:0]           value_i,
  input  logic [BASE_W-1:0]                base_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [CHAR_W-1:0]                char_code_o,
  output logic                             last_o,
  output logic                             invalid_base_o
);

  logic [VALUE_WIDTH-1:0] quot_q, quot_d;
  logic [DIGIT_W-1:0]     rem_q, rem_d;
  logic [BASE_W-1:0]      base_q;
  logic                   neg_dec_q;
  logic                   in_neg_dec;
  logic [DIGIT_W:0]       trial;
  logic [DIGIT_W:0]       diff;
  logic                   fits;
  logic [DIGIT_W-1:0]     rd_digit;
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      char_q;
  logic                   last_q;
  logic                   inv_q;
  logic                   out_free;

  assign in_neg_dec = value_i[VALUE_WIDTH-1] && (base_i == BASE_DEC);

  // One restoring-division step: shift in the next dividend bit and try the base.
  assign trial = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, base_q};
  assign fits  = (trial >= {1'b0, base_q});

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    if (cmd_i.load) begin
      quot_d = in_neg_dec ? (~value_i + 1'b1) : value_i;
      rem_d  = '0;
    end else if (cmd_i.step) begin
      quot_d = {quot_q[VALUE_WIDTH-2:0], fits};
      rem_d  = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end else if (cmd_i.store) begin
      rem_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (cmd_i.load) begin
      base_q    <= base_i;
      neg_dec_q <= in_neg_dec;
    end
  end

  irt_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digit_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (wr_addr_i),
    .wdata_i (rem_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_digit)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_minus || cmd_i.out_digit || cmd_i.out_inv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_minus) begin
      char_q <= CHAR_MINUS;
      last_q <= 1'b0;
      inv_q  <= 1'b0;
    end else if (cmd_i.out_digit) begin
      char_q <= digit_char(rd_digit);
      last_q <= cmd_i.out_last;
      inv_q  <= 1'b0;
    end else if (cmd_i.out_inv) begin
      char_q <= CHAR_NONE;
      last_q <= 1'b1;
      inv_q  <= 1'b1;
    end
  end

  assign status_o.invalid   = (base_q < BASE_MIN) || (base_q > BASE_MAX);
  assign status_o.neg_dec   = neg_dec_q;
  assign status_o.quot_zero = (quot_q == '0);
  assign status_o.out_free  = out_free;

  assign out_valid_o    = out_valid_q;
  assign char_code_o    = char_q;
  assign last_o         = last_q;
  assign invalid_base_o = inv_q;

endmodule

/* hdl/irt_ctrl.sv */
// Controller: sequences division steps, digit stores and character output.
// Depends on irt_pkg for the command and status types.
module irt_ctrl
  import irt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  status_t                        status_i,
  output cmd_t                           cmd_o,
  output logic [$clog2(VALUE_WIDTH)-1:0] wr_addr_o,
  output logic [$clog2(VALUE_WIDTH)-1:0] rd_addr_o
);

  localparam int unsigned AW = $clog2(VALUE_WIDTH);
  localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);
  localparam logic [AW-1:0] BIT_LAST  = AW'(VALUE_WIDTH - 1);
  localparam logic [CW-1:0] DIGIT_CAP = CW'(VALUE_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MINUS,
    S_DIV,
    S_STORE,
    S_READ,
    S_EMIT,
    S_INV
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] bit_cnt_q, bit_cnt_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] n_inc;
  logic [AW-1:0] rd_idx_q, rd_idx_d;

  assign n_inc = n_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    bit_cnt_d = bit_cnt_q;
    n_d       = n_q;
    rd_idx_d  = rd_idx_q;
    cmd_o     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        bit_cnt_d = '0;
        n_d       = '0;
        if (status_i.invalid) begin
          state_d = S_INV;
        end else if (status_i.neg_dec) begin
          state_d = S_MINUS;
        end else begin
          state_d = S_DIV;
        end
      end
      S_MINUS: begin
        if (status_i.out_free) begin
          cmd_o.out_minus = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        bit_cnt_d  = bit_cnt_q + 1'b1;
        if (bit_cnt_q == BIT_LAST) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        n_d         = n_inc;
        bit_cnt_d   = '0;
        if (status_i.quot_zero || (n_inc == DIGIT_CAP)) begin
          rd_idx_d = n_q[AW-1:0];
          state_d  = S_READ;
        end else begin
          state_d = S_DIV;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_digit = 1'b1;
          cmd_o.out_last  = (rd_idx_q == '0);
          if (rd_idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q - 1'b1;
            state_d  = S_READ;
          end
        end
      end
      S_INV: begin
        if (status_i.out_free) begin
          cmd_o.out_inv = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bit_cnt_q <= '0;
      n_q       <= '0;
      rd_idx_q  <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      n_q       <= n_d;
      rd_idx_q  <= rd_idx_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign wr_addr_o  = n_q[AW-1:0];
  assign rd_addr_o  = rd_idx_q;

endmodule

/* hdl/integer_to_radix_text.sv */
// Integer to radix text: one character request out per digit, MSB first.
// A leading '-' for a negative base-ten value is loaded into the output
// register before division starts; the digits follow once all are stored.
// A new request is taken only after the last character of the previous one
// has been loaded into the output register; the divider produces one quotient bit per cycle.
// Reset: rst_ni is asynchronous and active low; it returns the controller to idle
// and empties the output register. The digit store is not cleared.
module integer_to_radix_text
  import irt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  irt_in_if.sink    req_i,
  irt_out_if.source rsp_o
);

  // Command and status between the controller and the datapath.
  cmd_t    cmd;
  status_t status;

  // Digit store addresses: the write address is the running digit count,
  // the read address walks back down from the most significant digit.
  logic [$clog2(VALUE_WIDTH)-1:0] wr_addr;
  logic [$clog2(VALUE_WIDTH)-1:0] rd_addr;

  // The controller accepts a request only when idle. Each digit takes
  // VALUE_WIDTH restoring-division steps followed by a store; once
  // the quotient reaches zero the digits are read back and handed to the
  // output register one at a time, waiting on the downstream ready.
  irt_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr)
  );

  // The datapath holds the divider, the digit store and the output register,
  // so the next request may enter while the final character still waits.
  irt_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .wr_addr_i      (wr_addr),
    .rd_addr_i      (rd_addr),
    .value_i        (req_i.value),
    .base_i         (req_i.base),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .char_code_o    (rsp_o.char_code),
    .last_o         (rsp_o.last),
    .invalid_base_o (rsp_o.invalid_base)
  );

endmodule

/* verif/integer_to_radix_text_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_radix_text: drives conversion requests,
// predicts the character stream and compares it field by field. Uses irt_pkg and
// the irt_in_if / irt_out_if channel interfaces of the block.
module integer_to_radix_text_test;
  import irt_pkg::*;

  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned RANDOM_REQUESTS = 126;
  // The slowest correct run is about 150 requests of 32 characters, each character
  // waiting out a receiver stall as well as its divider steps.
  localparam int unsigned CYCLE_LIMIT     = 1500000;
  localparam int unsigned LONG_HOLD       = 3000;
  localparam int unsigned DRAIN_CYCLES    = 200;
  localparam int unsigned MAX_REPORTS     = 40;

  // One character of converted text as it should leave the block.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last_flag;
    logic              bad_base;
  } text_char_t;

  // Keeps the characters still owed by the block, oldest first, and checks
  // every character that the receiver accepts against them.
  class text_scoreboard;
    text_char_t  pending_chars[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function int unsigned pending_count();
      return pending_chars.size();
    endfunction

    // Works out the full text of one accepted request and queues it.
    function void note_request(logic [VALUE_W-1:0] value, logic [BASE_W-1:0] base);
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] radix;
      logic [DIGIT_W-1:0] digits [VALUE_W];
      logic [DIGIT_W-1:0] d;
      int                 n;
      text_char_t         ch;
      if (base < BASE_MIN || base > BASE_MAX) begin
        ch = '{code: CHAR_NONE, last_flag: 1'b1, bad_base: 1'b1};
        pending_chars.push_back(ch);
        return;
      end
      mag   = value;
      radix = {{(VALUE_W-BASE_W){1'b0}}, base};
      // Only base ten gets a sign; every other base sees the raw bit pattern.
      if (value[VALUE_W-1] && base == BASE_DEC) begin
        ch = '{code: CHAR_MINUS, last_flag: 1'b0, bad_base: 1'b0};
        pending_chars.push_back(ch);
        mag = -value;
      end
      n = 0;
      do begin
        digits[n] = DIGIT_W'(mag % radix);
        n++;
        mag = mag / radix;
      end while (mag != 0 && n < VALUE_W);
      for (int i = n - 1; i >= 0; i--) begin
        d = digits[i];
        ch.code      = (d < DIGIT_TEN) ? CHAR_ZERO + CHAR_W'(d)
                                       : CHAR_LOW_A + CHAR_W'(d - DIGIT_TEN);
        ch.last_flag = (i == 0);
        ch.bad_base  = 1'b0;
        pending_chars.push_back(ch);
      end
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t ns: %s", $time, what);
      end
    endtask

    task check_char(logic [CHAR_W-1:0] code, logic last_flag, logic bad_base);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("character %h arrived with no request outstanding",
                                  code));
        return;
      end
      want = pending_chars.pop_front();
      if (code !== want.code) begin
        report_mismatch($sformatf("char_code %h, wanted %h", code, want.code));
      end
      if (last_flag !== want.last_flag) begin
        report_mismatch($sformatf("last %b, wanted %b on char %h",
                                  last_flag, want.last_flag, want.code));
      end
      if (bad_base !== want.bad_base) begin
        report_mismatch($sformatf("invalid_base %b, wanted %b on char %h",
                                  bad_base, want.bad_base, want.code));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  irt_in_if #(.VALUE_WIDTH(VALUE_W)) req_if ();
  irt_out_if                         rsp_if ();

  integer_to_radix_text #(
    .VALUE_WIDTH(VALUE_W)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  text_scoreboard sb = new();

  // Random idle bursts on both sides are switched off for the last stretch so
  // that back-to-back traffic is seen too.
  bit          bursts_on;
  // Set by the stimulus to ask the receiver for one long stall.
  bit          long_hold_request;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("integer_to_radix_text: mismatch");
    $finish;
  end

  // Offers one request, possibly after an idle burst, and returns once the block
  // has taken it. Sampling right after the edge sees the values the flops saw.
  task send_request(logic [VALUE_W-1:0] value, logic [BASE_W-1:0] base);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.value <= value;
    req_if.base  <= base;
    do begin
      @(posedge clk);
    end while (!req_if.ready);
    sb.note_request(value, base);
  endtask

  // Lowers valid and waits until the block has delivered everything owed.
  task drain_results();
    req_if.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  // Receiver: checks every accepted character, then decides on ready for the
  // next cycle. Short stalls come in bursts; a long stall is counted here when
  // the stimulus asks for one, so the block backs up while requests keep coming.
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_char(rsp_if.char_code, rsp_if.last, rsp_if.invalid_base);
      end
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        hold_left         = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
        hold_left    = $urandom_range(0, 9);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, a directed set of corner cases, then random requests.
  initial begin
    logic [VALUE_W-1:0] rand_value;
    logic [BASE_W-1:0]  rand_base;
    int unsigned        shape;

    bursts_on         = 1'b1;
    long_hold_request = 1'b0;
    rst_n        <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.value <= '0;
    req_if.base  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero in two bases, single digits, and the top digit of base 36.
    send_request(32'd0, 6'd10);
    send_request(32'd0, 6'd2);
    send_request(32'd1, 6'd2);
    send_request(32'd35, 6'd36);
    send_request(32'd10, 6'd36);
    send_request(32'd36, 6'd36);
    // Negative values: signed in base ten, raw bit pattern elsewhere.
    send_request(-32'sd1, 6'd10);
    send_request(-32'sd1, 6'd2);
    send_request(-32'sd1, 6'd16);
    send_request(-32'sd1, 6'd36);
    send_request(-32'sd5, 6'd10);
    send_request(-32'sd123, 6'd3);
    // The most negative value must print its true magnitude in base ten.
    send_request(32'h8000_0000, 6'd10);
    send_request(32'h8000_0000, 6'd2);
    send_request(32'h8000_0000, 6'd36);
    send_request(32'h7fff_ffff, 6'd10);
    send_request(32'h7fff_ffff, 6'd36);
    send_request(32'd255, 6'd16);
    send_request(32'd1234567890, 6'd10);
    send_request(32'd7, 6'd8);
    // Bases outside 2 to 36 give a single flagged character.
    send_request(32'd99, 6'd0);
    send_request(32'd99, 6'd1);
    send_request(-32'sd7, 6'd37);
    send_request(32'hffff_ffff, 6'd63);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // Requests keep flowing while the receiver sits in one long stall.
      if (n == 20) begin
        long_hold_request = 1'b1;
      end
      // Once, let the block empty out completely before the next request.
      if (n == 70) begin
        drain_results();
      end
      if (n == RANDOM_REQUESTS - 40) begin
        bursts_on = 1'b0;
      end
      shape = $urandom_range(0, 9);
      if (shape < 5) begin
        rand_value = $urandom();
      end else if (shape < 8) begin
        rand_value = $urandom_range(0, 100);
        if ($urandom_range(0, 1) == 1) begin
          rand_value = -rand_value;
        end
      end else begin
        case ($urandom_range(0, 3))
          0: rand_value = 32'h8000_0000;
          1: rand_value = 32'h7fff_ffff;
          2: rand_value = 32'hffff_ffff;
          default: rand_value = 32'd0;
        endcase
      end
      shape = $urandom_range(0, 9);
      if (shape < 6) begin
        rand_base = BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
      end else if (shape < 8) begin
        rand_base = BASE_DEC;
      end else begin
        rand_base = BASE_W'($urandom_range(0, 63));
      end
      send_request(rand_value, rand_base);
    end

    drain_results();
    // A little extra time so a stray extra character would still be caught.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatch_count == 0 && sb.pending_count() == 0) begin
      $display("integer_to_radix_text: match");
    end else begin
      $display("integer_to_radix_text: mismatch");
    end
    $finish;
  end

endmodule
